// ----- hw/rtl/fcn_pkg.sv -----
// Types and constants shared by the face corner normaliser and its checker.
package fcn_pkg;

    // Field widths fixed by the face format
    localparam int VERT_W  = 24;
    localparam int ATTR_W  = 64;
    localparam int COUNT_W = 3;
    localparam int EDGE_W  = 4;
    localparam int FLIP_W  = 8;

    // Significant bits of an index and of an attribute word
    localparam int INDEX_BITS = 24;
    localparam int ATTR_BITS  = 64;

    localparam logic [VERT_W-1:0] IDX_MASK =
        (INDEX_BITS >= VERT_W) ? {VERT_W{1'b1}}
                               : VERT_W'((64'd1 << INDEX_BITS) - 64'd1);
    localparam logic [ATTR_W-1:0] ATTR_MASK =
        (ATTR_BITS >= ATTR_W) ? {ATTR_W{1'b1}}
                              : ATTR_W'((64'd1 << ATTR_BITS) - 64'd1);

    // Flip bits above the per-corner nibble pass through untouched
    localparam logic [FLIP_W-1:0] FLIP_KEEP_MASK = ~FLIP_W'(15);

    // Working count after duplicate removal: one extra bit so that an
    // underflow never aliases a valid corner count
    localparam int WCOUNT_W = COUNT_W + 1;
    localparam logic [WCOUNT_W-1:0] CNT_EDGE = WCOUNT_W'(2);
    localparam logic [WCOUNT_W-1:0] CNT_TRI  = WCOUNT_W'(3);
    localparam logic [WCOUNT_W-1:0] CNT_QUAD = WCOUNT_W'(4);

    // Rotation applied in the last stage
    typedef enum logic [1:0] {
        ROT_NONE,
        ROT_PAIR,
        ROT_TRI,
        ROT_QUAD
    } rot_kind_t;

    // Input transaction
    typedef struct packed {
        logic [VERT_W-1:0]  vert_a;
        logic [VERT_W-1:0]  vert_b;
        logic [VERT_W-1:0]  vert_c;
        logic [VERT_W-1:0]  vert_d;
        logic [COUNT_W-1:0] corner_count;
        logic [EDGE_W-1:0]  edge_flags;
        logic [FLIP_W-1:0]  flip_flags;
        logic [ATTR_W-1:0]  corner_attr0;
        logic [ATTR_W-1:0]  corner_attr1;
        logic [ATTR_W-1:0]  corner_attr2;
        logic [ATTR_W-1:0]  corner_attr3;
    } face_t;

    // Output transaction
    typedef struct packed {
        logic [VERT_W-1:0] out_vert_a;
        logic [VERT_W-1:0] out_vert_b;
        logic [VERT_W-1:0] out_vert_c;
        logic [VERT_W-1:0] out_vert_d;
        logic [EDGE_W-1:0] out_edge_flags;
        logic [FLIP_W-1:0] out_flip_flags;
        logic [ATTR_W-1:0] out_attr0;
        logic [ATTR_W-1:0] out_attr1;
        logic [ATTR_W-1:0] out_attr2;
        logic [ATTR_W-1:0] out_attr3;
    } result_t;

    // Stage one: masked face plus duplicate compares
    typedef struct packed {
        logic [3:0][VERT_W-1:0] vert;
        logic [COUNT_W-1:0]     cnt;
        logic [EDGE_W-1:0]      edge_bits;
        logic [FLIP_W-1:0]      flip_bits;
        logic [3:0][ATTR_W-1:0] attr;
        logic                   dup_cd;
        logic                   dup_bc;
        logic                   dup_ab;
    } s1_t;

    // Stage two: duplicates removed, working count
    typedef struct packed {
        logic [3:0][VERT_W-1:0] vert;
        logic [WCOUNT_W-1:0]    cnt;
        logic [EDGE_W-1:0]      edge_bits;
        logic [FLIP_W-1:0]      flip_bits;
        logic [3:0][ATTR_W-1:0] attr;
    } s2_t;

    // Stage three: rotation chosen
    typedef struct packed {
        logic [3:0][VERT_W-1:0] vert;
        logic [EDGE_W-1:0]      edge_bits;
        logic [FLIP_W-1:0]      flip_bits;
        logic [3:0][ATTR_W-1:0] attr;
        rot_kind_t              rot;
    } s3_t;

endpackage

// ----- hw/rtl/face_corner_normalizer_top.sv -----
// Face corner normaliser: four-stage pipeline, duplicate removal and rotation.
//
//  Channel | Signals                          | Direction | Payload
//  --------+----------------------------------+-----------+-------------------
//  face    | face_valid, face_ready, face     | in        | fcn_pkg::face_t
//  result  | result_valid, result_ready, result | out     | fcn_pkg::result_t
//
// One face enters per cycle while the result channel drains; a result passes
// through the four register stages in order: compare, duplicate removal,
// rotation select, permutation/output register.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stage holds while the one after it is full and stalled, so a stalled
// result backs up the pipeline without losing or repeating a transaction.
module face_corner_normalizer_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             face_valid,
    output logic             face_ready,
    input  fcn_pkg::face_t   face,
    output logic             result_valid,
    input  logic             result_ready,
    output fcn_pkg::result_t result
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    fcn_pkg::s1_t     s1_reg, s1_next;
    fcn_pkg::s2_t     s2_reg, s2_next;
    fcn_pkg::s3_t     s3_reg, s3_next;
    fcn_pkg::result_t s4_reg, s4_next;

    // Backpressure: a stage may load when it is empty or its contents move on
    assign s4_ready   = !s4_valid_reg || result_ready;
    assign s3_ready   = !s3_valid_reg || s4_ready;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign face_ready = s1_ready;

    // Stage one: mask fields, compare neighbouring indices
    always_comb
    begin
        s1_next.vert[0]   = face.vert_a & fcn_pkg::IDX_MASK;
        s1_next.vert[1]   = face.vert_b & fcn_pkg::IDX_MASK;
        s1_next.vert[2]   = face.vert_c & fcn_pkg::IDX_MASK;
        s1_next.vert[3]   = face.vert_d & fcn_pkg::IDX_MASK;
        s1_next.cnt       = face.corner_count;
        s1_next.edge_bits = face.edge_flags;
        s1_next.flip_bits = face.flip_flags;
        s1_next.attr[0]   = face.corner_attr0 & fcn_pkg::ATTR_MASK;
        s1_next.attr[1]   = face.corner_attr1 & fcn_pkg::ATTR_MASK;
        s1_next.attr[2]   = face.corner_attr2 & fcn_pkg::ATTR_MASK;
        s1_next.attr[3]   = face.corner_attr3 & fcn_pkg::ATTR_MASK;
        // Earlier removals never touch the slots a later compare reads,
        // so all three compares work on the incoming indices
        s1_next.dup_cd = (s1_next.vert[2] != '0) && (s1_next.vert[2] == s1_next.vert[3]);
        s1_next.dup_bc = (s1_next.vert[1] != '0) && (s1_next.vert[1] == s1_next.vert[2]);
        s1_next.dup_ab = (s1_next.vert[0] == s1_next.vert[1]);
    end

    // Stage two: shift indices down over each duplicate, lower the count
    always_comb
    begin
        s2_next.vert      = s1_reg.vert;
        s2_next.edge_bits = s1_reg.edge_bits;
        s2_next.flip_bits = s1_reg.flip_bits;
        s2_next.attr      = s1_reg.attr;
        if (s1_reg.dup_cd)
        begin
            s2_next.vert[3] = '0;
        end
        if (s1_reg.dup_bc)
        begin
            s2_next.vert[2] = s2_next.vert[3];
            s2_next.vert[3] = '0;
        end
        if (s1_reg.dup_ab)
        begin
            s2_next.vert[1] = s2_next.vert[2];
            s2_next.vert[2] = s2_next.vert[3];
            s2_next.vert[3] = '0;
        end
        s2_next.cnt = {1'b0, s1_reg.cnt}
                      - fcn_pkg::WCOUNT_W'(s1_reg.dup_cd)
                      - fcn_pkg::WCOUNT_W'(s1_reg.dup_bc)
                      - fcn_pkg::WCOUNT_W'(s1_reg.dup_ab);
    end

    // Stage three: pick the rotation from working count and empty slots
    always_comb
    begin
        s3_next.vert      = s2_reg.vert;
        s3_next.edge_bits = s2_reg.edge_bits;
        s3_next.flip_bits = s2_reg.flip_bits;
        s3_next.attr      = s2_reg.attr;
        s3_next.rot       = fcn_pkg::ROT_NONE;
        if (s2_reg.cnt == fcn_pkg::CNT_EDGE)
        begin
            if (s2_reg.vert[1] == '0)
            begin
                s3_next.rot = fcn_pkg::ROT_PAIR;
            end
        end
        else if (s2_reg.cnt == fcn_pkg::CNT_TRI)
        begin
            if (s2_reg.vert[2] == '0)
            begin
                s3_next.rot = fcn_pkg::ROT_TRI;
            end
        end
        else if (s2_reg.cnt == fcn_pkg::CNT_QUAD)
        begin
            if ((s2_reg.vert[2] == '0) || (s2_reg.vert[3] == '0))
            begin
                s3_next.rot = fcn_pkg::ROT_QUAD;
            end
        end
    end

    // Stage four: apply the permutation to indices, and for triangle and quad rotations also to flags and attributes
    always_comb
    begin
        logic [3:0][fcn_pkg::VERT_W-1:0] v;
        logic [3:0][fcn_pkg::ATTR_W-1:0] at;
        logic [fcn_pkg::EDGE_W-1:0]      e;
        logic [fcn_pkg::FLIP_W-1:0]      f;
        v  = s3_reg.vert;
        at = s3_reg.attr;
        e  = s3_reg.edge_bits;
        f  = s3_reg.flip_bits;
        unique case (s3_reg.rot)
            fcn_pkg::ROT_PAIR:
            begin
                v[0] = s3_reg.vert[1];
                v[1] = s3_reg.vert[0];
            end
            fcn_pkg::ROT_TRI:
            begin
                v[0]  = s3_reg.vert[1];
                v[1]  = s3_reg.vert[2];
                v[2]  = s3_reg.vert[0];
                at[0] = s3_reg.attr[1];
                at[1] = s3_reg.attr[2];
                at[2] = s3_reg.attr[0];
                // a triangle has no edge or flip bit for slot d, so both are cleared
                e = {1'b0, s3_reg.edge_bits[0], s3_reg.edge_bits[2],
                     s3_reg.edge_bits[1]};
                f = (s3_reg.flip_bits & fcn_pkg::FLIP_KEEP_MASK)
                    | fcn_pkg::FLIP_W'({1'b0, s3_reg.flip_bits[1],
                                        s3_reg.flip_bits[0], s3_reg.flip_bits[2]});
            end
            fcn_pkg::ROT_QUAD:
            begin
                v[0]  = s3_reg.vert[2];
                v[1]  = s3_reg.vert[3];
                v[2]  = s3_reg.vert[0];
                v[3]  = s3_reg.vert[1];
                at[0] = s3_reg.attr[2];
                at[1] = s3_reg.attr[3];
                at[2] = s3_reg.attr[0];
                at[3] = s3_reg.attr[1];
                e = {s3_reg.edge_bits[3], s3_reg.edge_bits[0],
                     s3_reg.edge_bits[1], s3_reg.edge_bits[2]};
                f = (s3_reg.flip_bits & fcn_pkg::FLIP_KEEP_MASK)
                    | fcn_pkg::FLIP_W'({s3_reg.flip_bits[1], s3_reg.flip_bits[0],
                                        s3_reg.flip_bits[3], s3_reg.flip_bits[2]});
            end
            default:
            begin
                v  = s3_reg.vert;
            end
        endcase
        s4_next.out_vert_a     = v[0];
        s4_next.out_vert_b     = v[1];
        s4_next.out_vert_c     = v[2];
        s4_next.out_vert_d     = v[3];
        s4_next.out_edge_flags = e;
        s4_next.out_flip_flags = f;
        s4_next.out_attr0      = at[0];
        s4_next.out_attr1      = at[1];
        s4_next.out_attr2      = at[2];
        s4_next.out_attr3      = at[3];
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= face_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage payloads, loaded only when a valid transaction moves in
    always_ff @(posedge clk)
    begin
        if (s1_ready && face_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    assign result_valid = s4_valid_reg;
    assign result       = s4_reg;

endmodule

// ----- hw/rtl/fcn_checker.sv -----
// Port-level checker for the face corner normaliser, bound to the top level.
module fcn_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             face_valid,
    input logic             face_ready,
    input logic             result_valid,
    input logic             result_ready,
    input fcn_pkg::result_t result
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
    else $error("result payload changed while stalled");

    // With the output draining, the pipeline never pushes back
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> face_ready)
    else $error("face channel stalled although result channel drains");

    // An accepted face reaches the output when result_ready stays high while it moves through the stages
    assert property (@(posedge clk) disable iff (!rst_n)
        (face_valid && face_ready) ##1 result_ready ##1 result_ready ##1 result_ready
        |=> result_valid)
    else $error("accepted face did not reach the output in time");

endmodule

bind face_corner_normalizer_top fcn_checker u_fcn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .face_valid   (face_valid),
    .face_ready   (face_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
